>>> rtl/core/jlap_pkg.sv
// ---------------------------------------------------------------------------
// jlap_pkg: shared types and constants for the Jacobi grid cell update
// Value widths, command codes, controller states and memory control type.
// ---------------------------------------------------------------------------
package jlap_pkg;

  // Field widths
  localparam int VAL_W  = 24;
  localparam int SIDE_W = 7;
  localparam int ROW_W  = 6;
  localparam int COL_W  = 6;
  localparam int CMD_W  = 2;
  localparam int SUM_W  = VAL_W + 2;

  // Hot square value: 100 in Q7.17
  localparam logic [VAL_W-1:0]  HOT_VALUE     = 24'd13107200;
  localparam logic [SIDE_W-1:0] SIDE_MIN      = 7'd3;
  localparam logic [SIDE_W-1:0] GRID_SIZE_RST = 7'd64;

  // Division by ten through a reciprocal: exact for values below 1029
  localparam int TENTH_MUL_W = 8;
  localparam logic [TENTH_MUL_W-1:0] TENTH_MUL = 8'd205;
  localparam int TENTH_SHIFT = 11;

  typedef enum logic [CMD_W-1:0] {
    CMD_INIT = 2'd0,
    CMD_ITER = 2'd1,
    CMD_READ = 2'd2,
    CMD_SWAP = 2'd3
  } cmd_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_INIT,
    ST_ITER,
    ST_WRITE,
    ST_READ,
    ST_RDATA,
    ST_DONE
  } state_e;

  // Memory port control
  typedef struct packed {
    logic en;
    logic we;
  } mem_ctl_t;

endpackage

>>> rtl/core/jlap_mem.sv
// ---------------------------------------------------------------------------
// jlap_mem: single-port grid memory
// One read or one write per cycle; read data registered.
// ---------------------------------------------------------------------------
module jlap_mem #(
  parameter int DEPTH = 4096,
  parameter int AW    = 12
) (
  input  logic                    clk_i,
  input  jlap_pkg::mem_ctl_t      ctl_i,
  input  logic [AW-1:0]           addr_i,
  input  logic [jlap_pkg::VAL_W-1:0] wdata_i,
  output logic [jlap_pkg::VAL_W-1:0] rdata_o
);
  import jlap_pkg::*;

  logic [VAL_W-1:0] mem_q [DEPTH];
  logic [VAL_W-1:0] rdata_q;

  // Write or read the addressed entry
  always_ff @(posedge clk_i) begin
    if (ctl_i.en) begin
      if (ctl_i.we) begin
        mem_q[addr_i] <= wdata_i;
      end else begin
        rdata_q <= mem_q[addr_i];
      end
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> rtl/core/jlap_ctrl.sv
// ---------------------------------------------------------------------------
// jlap_ctrl: command sequencer for the two grid memories
// Walks init over every entry, gathers the four neighbours and the centre
// for an update, reads single cells and swaps the current/next roles.
// ---------------------------------------------------------------------------
module jlap_ctrl #(
  parameter int MAX_SIDE = 64,
  parameter int CELLS    = MAX_SIDE * MAX_SIDE,
  parameter int AW       = $clog2(CELLS)
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic [jlap_pkg::SIDE_W-1:0] side_i,
  // command input
  input  logic                        cmd_valid_i,
  output logic                        cmd_ready_o,
  input  logic [jlap_pkg::CMD_W-1:0]  cmd_i,
  input  logic [jlap_pkg::ROW_W-1:0]  row_i,
  input  logic [jlap_pkg::COL_W-1:0]  col_i,
  // result
  output logic                        res_valid_o,
  input  logic                        res_ready_i,
  output logic [jlap_pkg::VAL_W-1:0]  res_change_o,
  output logic [jlap_pkg::VAL_W-1:0]  res_value_o,
  // grid memories
  output jlap_pkg::mem_ctl_t          one_ctl_o,
  output logic [AW-1:0]               one_addr_o,
  input  logic [jlap_pkg::VAL_W-1:0]  one_rdata_i,
  output jlap_pkg::mem_ctl_t          two_ctl_o,
  output logic [AW-1:0]               two_addr_o,
  input  logic [jlap_pkg::VAL_W-1:0]  two_rdata_i,
  output logic [jlap_pkg::VAL_W-1:0]  wdata_o
);
  import jlap_pkg::*;

  localparam int PROD_W = ROW_W + SIDE_W;
  localparam int TEN_W  = SIDE_W + TENTH_MUL_W;
  localparam logic [AW-1:0] LAST_IDX = AW'(CELLS - 1);

  state_e            state_q, state_d;
  logic [AW-1:0]     addr_q, addr_d;
  logic [2:0]        k_q, k_d;
  logic [SUM_W-1:0]  sum_q, sum_d;
  logic [AW-1:0]     idx_q, idx_d;
  logic [AW-1:0]     irow_q, irow_d;
  logic [SIDE_W-1:0] icol_q, icol_d;
  logic [SIDE_W-1:0] lo_q, lo_d;
  logic [SIDE_W-1:0] hi_q, hi_d;
  logic [VAL_W-1:0]  change_q, change_d;
  logic [VAL_W-1:0]  value_q, value_d;
  logic              cur_two_q, cur_two_d;

  logic [PROD_W-1:0] addr_wide;
  logic [AW-1:0]     addr_calc;
  logic [AW-1:0]     side_aw;
  logic [TEN_W-1:0]  tenth_full;
  logic [SIDE_W-1:0] tenth;
  logic [SIDE_W-1:0] half;
  logic              border;
  logic              outside;
  logic              hot;
  logic [VAL_W-1:0]  cur_rdata;
  logic [VAL_W-1:0]  new_val;
  mem_ctl_t          cur_ctl, nxt_ctl;
  logic [AW-1:0]     cur_addr, nxt_addr;

  // Cell address and hot square bounds from the incoming command
  assign addr_wide  = PROD_W'(row_i) * PROD_W'(side_i) + PROD_W'(col_i);
  assign addr_calc  = AW'(addr_wide);
  assign side_aw    = AW'(side_i);
  assign tenth_full = TEN_W'(side_i) * TEN_W'(TENTH_MUL);
  assign tenth      = SIDE_W'(tenth_full >> TENTH_SHIFT);
  assign half       = side_i >> 1;

  assign border  = (row_i == '0) || (col_i == '0) ||
                   (SIDE_W'(row_i) >= side_i - SIDE_W'(1)) ||
                   (SIDE_W'(col_i) >= side_i - SIDE_W'(1));
  assign outside = (SIDE_W'(row_i) >= side_i) || (SIDE_W'(col_i) >= side_i);

  // Init walk position inside the hot square
  assign hot = (32'(irow_q) >= 32'(lo_q)) && (32'(irow_q) < 32'(hi_q)) &&
               (icol_q >= lo_q) && (icol_q < hi_q);

  assign cur_rdata = cur_two_q ? two_rdata_i : one_rdata_i;
  assign new_val   = sum_q[SUM_W-1:2];

  // Map current/next requests onto the physical grids
  assign one_ctl_o  = cur_two_q ? nxt_ctl  : cur_ctl;
  assign one_addr_o = cur_two_q ? nxt_addr : cur_addr;
  assign two_ctl_o  = cur_two_q ? cur_ctl  : nxt_ctl;
  assign two_addr_o = cur_two_q ? cur_addr : nxt_addr;

  assign res_change_o = change_q;
  assign res_value_o  = value_q;

  // State and datapath registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      cur_two_q <= 1'b0;
      k_q       <= '0;
    end else begin
      state_q   <= state_d;
      cur_two_q <= cur_two_d;
      k_q       <= k_d;
    end
  end

  always_ff @(posedge clk_i) begin
    addr_q   <= addr_d;
    sum_q    <= sum_d;
    idx_q    <= idx_d;
    irow_q   <= irow_d;
    icol_q   <= icol_d;
    lo_q     <= lo_d;
    hi_q     <= hi_d;
    change_q <= change_d;
    value_q  <= value_d;
  end

  // Next state, memory requests and result
  always_comb begin
    state_d   = state_q;
    addr_d    = addr_q;
    k_d       = k_q;
    sum_d     = sum_q;
    idx_d     = idx_q;
    irow_d    = irow_q;
    icol_d    = icol_q;
    lo_d      = lo_q;
    hi_d      = hi_q;
    change_d  = change_q;
    value_d   = value_q;
    cur_two_d = cur_two_q;

    cmd_ready_o = 1'b0;
    res_valid_o = 1'b0;
    cur_ctl     = '{en: 1'b0, we: 1'b0};
    nxt_ctl     = '{en: 1'b0, we: 1'b0};
    cur_addr    = addr_q;
    nxt_addr    = addr_q;
    wdata_o     = new_val;

    unique case (state_q)
      ST_IDLE: begin
        cmd_ready_o = 1'b1;
        if (cmd_valid_i) begin
          change_d = '0;
          value_d  = '0;
          sum_d    = '0;
          k_d      = '0;
          addr_d   = addr_calc;
          unique case (cmd_e'(cmd_i))
            CMD_INIT: begin
              idx_d   = '0;
              irow_d  = '0;
              icol_d  = '0;
              lo_d    = half;
              hi_d    = half + ((tenth == '0) ? SIDE_W'(1) : tenth);
              state_d = ST_INIT;
            end
            CMD_ITER: state_d = border ? ST_DONE : ST_ITER;
            CMD_READ: state_d = outside ? ST_DONE : ST_READ;
            CMD_SWAP: begin
              cur_two_d = !cur_two_q;
              state_d   = ST_DONE;
            end
            default: state_d = ST_DONE;
          endcase
        end
      end

      // Clear both grids, hot square where the walk passes over it
      ST_INIT: begin
        cur_ctl  = '{en: 1'b1, we: 1'b1};
        nxt_ctl  = '{en: 1'b1, we: 1'b1};
        cur_addr = idx_q;
        nxt_addr = idx_q;
        wdata_o  = hot ? HOT_VALUE : '0;
        idx_d    = idx_q + AW'(1);
        if (icol_q == side_i - SIDE_W'(1)) begin
          icol_d = '0;
          irow_d = irow_q + AW'(1);
        end else begin
          icol_d = icol_q + SIDE_W'(1);
        end
        if (idx_q == LAST_IDX) begin
          state_d = ST_DONE;
        end
      end

      // Issue up, left, right, down, centre; add each neighbour as it lands
      ST_ITER: begin
        cur_ctl = '{en: 1'b1, we: 1'b0};
        unique case (k_q)
          3'd0:    cur_addr = addr_q - side_aw;
          3'd1:    cur_addr = addr_q - AW'(1);
          3'd2:    cur_addr = addr_q + AW'(1);
          3'd3:    cur_addr = addr_q + side_aw;
          default: cur_addr = addr_q;
        endcase
        if (k_q != 3'd0) begin
          sum_d = sum_q + SUM_W'(cur_rdata);
        end
        k_d = k_q + 3'd1;
        if (k_q == 3'd4) begin
          state_d = ST_WRITE;
        end
      end

      // Centre value lands now: write the new cell and take the change
      ST_WRITE: begin
        nxt_ctl  = '{en: 1'b1, we: 1'b1};
        nxt_addr = addr_q;
        wdata_o  = new_val;
        change_d = (new_val >= cur_rdata) ? new_val - cur_rdata
                                          : cur_rdata - new_val;
        state_d  = ST_DONE;
      end

      ST_READ: begin
        cur_ctl  = '{en: 1'b1, we: 1'b0};
        cur_addr = addr_q;
        state_d  = ST_RDATA;
      end

      ST_RDATA: begin
        value_d = cur_rdata;
        state_d = ST_DONE;
      end

      // Hold the result until the output stage takes it
      ST_DONE: begin
        res_valid_o = 1'b1;
        if (res_ready_i) begin
          state_d = ST_IDLE;
        end
      end

      default: state_d = ST_IDLE;
    endcase
  end

endmodule

>>> rtl/core/jacobi_laplace_grid_cell_update_top.sv
// ---------------------------------------------------------------------------
// jacobi_laplace_grid_cell_update_top: five-point Jacobi cell update block
// Holds a current and a next grid of Q7.17 values in two single-port
// memories and runs init, cell update, cell read and swap commands.
//
// Usage:
//   Slave channel: one word per command. tuser carries the command
//   (0 init, 1 update cell, 2 read cell, 3 swap), tdata the row and column.
//   Master channel: one word per command with the absolute change of an
//   update and the cell value of a read; unused fields are zero.
//   grid_size is written through cfg_we_i/cfg_wdata_i while the block is
//   idle; it is saturated to 3..MAX_SIDE.
//   Init writes one memory entry of both grids per cycle and walks all
//   MAX_SIDE*MAX_SIDE entries of the memories.
//   The update time is set by five reads through the single port of the
//   current grid. One command is worked at a time; the next is taken once
//   the result has moved into the output register.
//   Reset clears control state, selects grid one as current and sets
//   grid_size to 64; grid contents are undefined until the first init.
//   A stalled master holds its word; the sequencer then holds a finished
//   result and stops taking commands until the output register frees.
// ---------------------------------------------------------------------------
module jacobi_laplace_grid_cell_update_top #(
  parameter int MAX_SIDE = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration: grid_size
  input  logic        cfg_we_i,
  input  logic [6:0]  cfg_wdata_i,
  // commands
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [15:0] s_axis_tdata_i,  // [5:0] row, [11:6] col, [15:12] zero
  input  logic [1:0]  s_axis_tuser_i,  // [1:0] command
  // results
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [47:0] m_axis_tdata_o   // [23:0] change, [47:24] cell_value
);
  import jlap_pkg::*;

  localparam int CELLS = MAX_SIDE * MAX_SIDE;
  localparam int AW    = $clog2(CELLS);

  logic [SIDE_W-1:0] grid_size_q;
  logic [SIDE_W-1:0] side;
  logic              res_valid;
  logic              res_ready;
  logic [VAL_W-1:0]  res_change;
  logic [VAL_W-1:0]  res_value;
  logic              out_valid_q, out_valid_d;
  logic [VAL_W-1:0]  out_change_q, out_value_q;
  mem_ctl_t          one_ctl, two_ctl;
  logic [AW-1:0]     one_addr, two_addr;
  logic [VAL_W-1:0]  one_rdata, two_rdata;
  logic [VAL_W-1:0]  wdata;
  logic              out_load;

  // Grid size register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      grid_size_q <= GRID_SIZE_RST;
    end else if (cfg_we_i) begin
      grid_size_q <= cfg_wdata_i;
    end
  end

  // Saturate the side in use to 3..MAX_SIDE
  always_comb begin
    if (grid_size_q < SIDE_MIN) begin
      side = SIDE_MIN;
    end else if (32'(grid_size_q) > MAX_SIDE) begin
      side = SIDE_W'(MAX_SIDE);
    end else begin
      side = grid_size_q;
    end
  end

  jlap_ctrl #(
    .MAX_SIDE (MAX_SIDE),
    .CELLS    (CELLS),
    .AW       (AW)
  ) u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .side_i       (side),
    .cmd_valid_i  (s_axis_tvalid_i),
    .cmd_ready_o  (s_axis_tready_o),
    .cmd_i        (s_axis_tuser_i),
    .row_i        (s_axis_tdata_i[5:0]),
    .col_i        (s_axis_tdata_i[11:6]),
    .res_valid_o  (res_valid),
    .res_ready_i  (res_ready),
    .res_change_o (res_change),
    .res_value_o  (res_value),
    .one_ctl_o    (one_ctl),
    .one_addr_o   (one_addr),
    .one_rdata_i  (one_rdata),
    .two_ctl_o    (two_ctl),
    .two_addr_o   (two_addr),
    .two_rdata_i  (two_rdata),
    .wdata_o      (wdata)
  );

  jlap_mem #(
    .DEPTH (CELLS),
    .AW    (AW)
  ) u_grid_one (
    .clk_i   (clk_i),
    .ctl_i   (one_ctl),
    .addr_i  (one_addr),
    .wdata_i (wdata),
    .rdata_o (one_rdata)
  );

  jlap_mem #(
    .DEPTH (CELLS),
    .AW    (AW)
  ) u_grid_two (
    .clk_i   (clk_i),
    .ctl_i   (two_ctl),
    .addr_i  (two_addr),
    .wdata_i (wdata),
    .rdata_o (two_rdata)
  );

  // Output register: load when empty or being drained
  assign res_ready = !out_valid_q || m_axis_tready_i;
  assign out_load  = res_valid && res_ready;

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_change_q <= res_change;
      out_value_q  <= res_value;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {out_value_q, out_change_q};

endmodule
